// ===== rtl/core/pca_pkg.sv =====
package pca_pkg;

  // Widths of the fields and registers
  localparam int ChanW    = 8;
  localparam int OffsetW  = 9;
  localparam int GainW    = 10;
  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 3;
  localparam int NumChan  = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegRedOffset   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGreenOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlueOffset  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRedGain     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGreenGain   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlueGain    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGreyMode    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSixBit      = 3'd7;

  // Reciprocal of 3: floor(x * 683 / 2048) == floor(x / 3) for x <= 765
  localparam logic [9:0] RecipThree = 10'd683;
  localparam int         RecipShift = 11;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             last_in;
  } in_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             last_out;
  } out_beat_t;

  typedef struct packed {
    logic signed [NumChan-1:0][OffsetW-1:0] offset;
    logic signed [NumChan-1:0][GainW-1:0]   gain;
    logic                                   grey_mode;
    logic                                   six_bit;
  } cfg_t;

endpackage

// ===== rtl/core/pca_cfg_regs.sv =====
module pca_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pca_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pca_pkg::CfgDataW-1:0]  cfg_wdata,
  output pca_pkg::cfg_t                 cfg
);
  import pca_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register file decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        RegRedOffset:   cfg_nxt.offset[0] = cfg_wdata[OffsetW-1:0];
        RegGreenOffset: cfg_nxt.offset[1] = cfg_wdata[OffsetW-1:0];
        RegBlueOffset:  cfg_nxt.offset[2] = cfg_wdata[OffsetW-1:0];
        RegRedGain:     cfg_nxt.gain[0]   = cfg_wdata[GainW-1:0];
        RegGreenGain:   cfg_nxt.gain[1]   = cfg_wdata[GainW-1:0];
        RegBlueGain:    cfg_nxt.gain[2]   = cfg_wdata[GainW-1:0];
        RegGreyMode:    cfg_nxt.grey_mode = cfg_wdata[0];
        RegSixBit:      cfg_nxt.six_bit   = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pca_chan_adj.sv =====
module pca_chan_adj (
  input  logic [pca_pkg::ChanW-1:0]          chan,
  input  logic signed [pca_pkg::OffsetW-1:0] offset,
  input  logic signed [pca_pkg::GainW-1:0]   gain,
  output logic [pca_pkg::ChanW-1:0]          result
);
  import pca_pkg::*;

  // t spans -256..510, product fits 20 bits, quotient and sum fit 12 bits
  logic signed [9:0]  t;
  logic signed [19:0] prod;
  logic signed [19:0] prod_rnd;
  logic signed [11:0] quot;
  logic signed [11:0] total;

  assign t = $signed({2'b00, chan}) + 10'(offset);
  assign prod = 20'(t) * 20'(gain);

  // Divide by 256 truncating toward zero: bias negatives before the shift
  assign prod_rnd = prod[19] ? (prod + 20'sd255) : prod;
  assign quot = 12'(prod_rnd >>> 8);

  assign total = 12'(t) + quot;

  // Clamp to 0..255
  always_comb begin
    if (total < 12'sd0) begin
      result = '0;
    end else if (total > 12'sd255) begin
      result = '1;
    end else begin
      result = total[ChanW-1:0];
    end
  end

endmodule

// ===== rtl/core/pca_colour_calc.sv =====
module pca_colour_calc (
  input  pca_pkg::in_beat_t  in_beat,
  input  pca_pkg::cfg_t      cfg,
  output pca_pkg::out_beat_t out_beat
);
  import pca_pkg::*;

  logic [NumChan-1:0][ChanW-1:0] chan;
  logic [NumChan-1:0][ChanW-1:0] adj;
  logic [NumChan-1:0][ChanW-1:0] sel;
  logic [9:0]                    sum;
  logic [19:0]                   sum_scaled;
  logic [ChanW-1:0]              avg;

  assign chan[0] = in_beat.red_in;
  assign chan[1] = in_beat.green_in;
  assign chan[2] = in_beat.blue_in;

  // One adjust lane per channel
  for (genvar g = 0; g < NumChan; g++) begin : g_lane
    pca_chan_adj u_adj (
      .chan   (chan[g]),
      .offset (cfg.offset[g]),
      .gain   (cfg.gain[g]),
      .result (adj[g])
    );
  end

  // Grey average by reciprocal multiply
  assign sum = 10'(chan[0]) + 10'(chan[1]) + 10'(chan[2]);
  assign sum_scaled = 20'(sum) * 20'(RecipThree);
  assign avg = sum_scaled[RecipShift +: ChanW];

  // Mode select and optional six-bit scaling
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      sel[i] = cfg.grey_mode ? avg : adj[i];
      if (cfg.six_bit) begin
        sel[i] = {2'b00, sel[i][ChanW-1:2]};
      end
    end
  end

  assign out_beat.red_out   = sel[0];
  assign out_beat.green_out = sel[1];
  assign out_beat.blue_out  = sel[2];
  assign out_beat.last_out  = in_beat.last_in;

endmodule

// ===== rtl/core/palette_color_adjust_unit.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   pca_pkg::in_beat_t in_data
// out_      output     out_valid/out_stall pca_pkg::out_beat_t out_data
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// One beat per cycle unless stalled; out_valid rises as in_r moves to out_r.
// The path is in_r, a 10x10 multiply and clamp per channel, out_r.
// Synchronous active-low reset clears valid flags and all configuration to 0.
// in_stall rises only when both registers hold beats and out_stall is high.
module palette_color_adjust_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pca_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pca_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [pca_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pca_pkg::CfgDataW-1:0]  cfg_wdata
);
  import pca_pkg::*;

  cfg_t      cfg;
  in_beat_t  in_r;
  logic      in_valid_r;
  logic      in_valid_nxt;
  out_beat_t calc;
  out_beat_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      in_take;
  logic      advance;

  pca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pca_colour_calc u_calc (
    .in_beat  (in_r),
    .cfg      (cfg),
    .out_beat (calc)
  );

  // Handshake: result register frees when empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= calc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held input beat always moves into the result register when it frees
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && advance |=> out_valid_r && out_r.last_out == $past(in_r.last_in))
    else $error("held beat not moved to result register");

  // Grey mode gives three equal channels
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && advance && cfg.grey_mode |=>
      out_r.red_out == out_r.green_out && out_r.green_out == out_r.blue_out)
    else $error("grey result channels differ");

  // Six-bit mode keeps results below 64
  a_six: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && advance && cfg.six_bit |=>
      out_r.red_out[7:6] == 2'b00 && out_r.green_out[7:6] == 2'b00 &&
      out_r.blue_out[7:6] == 2'b00)
    else $error("six-bit result out of range");

  // No beat lost: a stalled result with a held input keeps both
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && in_valid_r |=> out_valid_r && in_valid_r)
    else $error("beat dropped while stalled");

endmodule
